// ===== design/vn_pkg.sv =====
// Shared constants for the vector normalization block.
// No dependencies; used by vn_front, vn_queue, vn_back and the top level.
package vn_pkg;

    // Number of vector components handled per item
    localparam int NUM_COMP = 3;

    // Entries in the queue between front and back pipelines
    localparam int QUEUE_DEPTH = 4;

endpackage

// ===== design/vn_front.sv =====
// Front pipeline: magnitude/sign split, component squares, sum of squares.
// Depends on vn_pkg.
module vn_front #(
    parameter int CW = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [vn_pkg::NUM_COMP*CW-1:0]   i_comp,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [vn_pkg::NUM_COMP*CW-1:0]   o_mag,
    output logic [vn_pkg::NUM_COMP-1:0]      o_neg,
    output logic [2*CW-1:0]                  o_sum
);
    localparam int NC = vn_pkg::NUM_COMP;

    logic                 w_adv;
    logic                 r_v1, r_v2, r_v3;
    logic [NC*CW-1:0]     r_mag1, r_mag2, r_mag3;
    logic [NC-1:0]        r_neg1, r_neg2, r_neg3;
    logic [NC*CW-1:0]     n_mag1;
    logic [NC-1:0]        n_neg1;
    logic [NC*2*CW-1:0]   r_sq2;
    logic [NC*2*CW-1:0]   n_sq2;
    logic [2*CW-1:0]      r_sum3;
    logic [2*CW+1:0]      n_sum3;

    // Whole pipeline moves unless the last stage holds an untaken item
    assign w_adv   = !r_v3 || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v3;
    assign o_mag   = r_mag3;
    assign o_neg   = r_neg3;
    assign o_sum   = r_sum3;

    // Stage 1: two's complement magnitude; most negative value maps to 2^(CW-1)
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_neg1[c] = i_comp[c*CW + CW - 1];
            n_mag1[c*CW +: CW] = n_neg1[c] ? (~i_comp[c*CW +: CW] + CW'(1))
                                           : i_comp[c*CW +: CW];
        end
    end

    // Stage 2: one multiplier per component
    always_comb begin
        for (int c = 0; c < NC; c++) begin
            n_sq2[c*2*CW +: 2*CW] = (2*CW)'(r_mag1[c*CW +: CW]) *
                                    (2*CW)'(r_mag1[c*CW +: CW]);
        end
    end

    // Stage 3: sum of squares, always below 2^(2*CW)
    always_comb begin
        n_sum3 = '0;
        for (int c = 0; c < NC; c++) begin
            n_sum3 = n_sum3 + (2*CW+2)'(r_sq2[c*2*CW +: 2*CW]);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mag1 <= n_mag1;
            r_neg1 <= n_neg1;
            r_mag2 <= r_mag1;
            r_neg2 <= r_neg1;
            r_sq2  <= n_sq2;
            r_mag3 <= r_mag2;
            r_neg3 <= r_neg2;
            r_sum3 <= n_sum3[2*CW-1:0];
        end
    end

endmodule

// ===== design/vn_queue.sv =====
// Small FIFO decoupling the front and back pipelines.
// Depends on vn_pkg for its depth.
module vn_queue #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [W-1:0] i_data,
    output logic         o_valid,
    input  logic         i_ready,
    output logic [W-1:0] o_data
);
    localparam int D  = vn_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);

    logic [W-1:0]  r_mem [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_ready = r_cnt != (AW+1)'(D);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_valid && o_ready;
    assign w_rd    = o_valid && i_ready;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + AW'(1);
            if (w_rd) r_rp <= r_rp + AW'(1);
            if (w_wr && !w_rd) r_cnt <= r_cnt + (AW+1)'(1);
            else if (!w_wr && w_rd) r_cnt <= r_cnt - (AW+1)'(1);
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== design/vn_back.sv =====
// Back pipeline: one square-root digit per stage, then one quotient bit per
// stage for all three lanes, then sign restore. Depends on vn_pkg.
module vn_back #(
    parameter int CW = 32,
    parameter int F  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [vn_pkg::NUM_COMP*CW-1:0]  i_mag,
    input  logic [vn_pkg::NUM_COMP-1:0]     i_neg,
    input  logic [2*CW-1:0]                 i_sum,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [F+1:0]                    o_unit_x,
    output logic [F+1:0]                    o_unit_y,
    output logic [F+1:0]                    o_unit_z,
    output logic                            o_zero_length
);
    localparam int NC = vn_pkg::NUM_COMP;
    localparam int RB = CW;
    localparam int RW = RB + 3;
    localparam int DW = CW + F + 1;
    localparam int QB = F + 1;
    localparam int NS = F + 1;

    logic w_adv;

    // Square root stages
    logic             r_sv    [1:RB];
    logic [RW-1:0]    r_srem  [1:RB];
    logic [RB-1:0]    r_sroot [1:RB];
    logic [2*CW-1:0]  r_sn    [1:RB];
    logic [NC*CW-1:0] r_smag  [1:RB];
    logic [NC-1:0]    r_sneg  [1:RB];

    // Division stages
    logic             r_dv    [1:NS];
    logic [RB-1:0]    r_dlen  [1:NS];
    logic [NC*DW-1:0] r_drem  [1:NS];
    logic [NC*QB-1:0] r_dq    [1:NS];
    logic [NC-1:0]    r_dneg  [1:NS];

    // Output register
    logic             r_ov;
    logic [F+1:0]     r_ux, r_uy, r_uz;
    logic             r_zl;
    logic [NC*(F+2)-1:0] n_unit;
    logic             n_zl;

    assign w_adv   = !r_ov || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_ov;
    assign o_unit_x = r_ux;
    assign o_unit_y = r_uy;
    assign o_unit_z = r_uz;
    assign o_zero_length = r_zl;

    // Floor square root, one result bit per stage
    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        logic             w_v;
        logic [RW-1:0]    w_rem;
        logic [RB-1:0]    w_root;
        logic [2*CW-1:0]  w_n;
        logic [NC*CW-1:0] w_mag;
        logic [NC-1:0]    w_neg;
        logic [RW-1:0]    n_rem, w_sh, w_trial;
        logic [RB-1:0]    n_root;

        if (k == 0) begin : g_in
            assign w_v    = i_valid;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_n    = i_sum;
            assign w_mag  = i_mag;
            assign w_neg  = i_neg;
        end else begin : g_reg
            assign w_v    = r_sv[k];
            assign w_rem  = r_srem[k];
            assign w_root = r_sroot[k];
            assign w_n    = r_sn[k];
            assign w_mag  = r_smag[k];
            assign w_neg  = r_sneg[k];
        end

        // Bring down two bits, try root*4+1
        always_comb begin
            w_sh    = {w_rem[RW-3:0], w_n[2*CW-1 -: 2]};
            w_trial = RW'({w_root, 2'b01});
            if (w_sh >= w_trial) begin
                n_rem  = w_sh - w_trial;
                n_root = {w_root[RB-2:0], 1'b1};
            end else begin
                n_rem  = w_sh;
                n_root = {w_root[RB-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_sv[k+1] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_srem[k+1]  <= n_rem;
                r_sroot[k+1] <= n_root;
                r_sn[k+1]    <= {w_n[2*CW-3:0], 2'b00};
                r_smag[k+1]  <= w_mag;
                r_sneg[k+1]  <= w_neg;
            end
        end
    end

    // Restoring division, one quotient bit per stage, all lanes in parallel
    for (genvar j = 0; j < NS; j++) begin : g_div
        localparam int B = F - j;
        logic             w_v;
        logic [RB-1:0]    w_len;
        logic [NC*DW-1:0] w_rem;
        logic [NC*QB-1:0] w_q;
        logic [NC-1:0]    w_neg;
        logic [DW-1:0]    w_dvs;
        logic [NC*DW-1:0] n_rem;
        logic [NC*QB-1:0] n_q;

        if (j == 0) begin : g_in
            assign w_v   = r_sv[RB];
            assign w_len = r_sroot[RB];
            assign w_q   = '0;
            assign w_neg = r_sneg[RB];
            for (genvar c = 0; c < NC; c++) begin : g_lane
                assign w_rem[c*DW +: DW] = DW'({r_smag[RB][c*CW +: CW], F'(0)});
            end
        end else begin : g_reg
            assign w_v   = r_dv[j];
            assign w_len = r_dlen[j];
            assign w_rem = r_drem[j];
            assign w_q   = r_dq[j];
            assign w_neg = r_dneg[j];
        end

        assign w_dvs = DW'(w_len) << B;

        // Compare and subtract per lane
        always_comb begin
            for (int c = 0; c < NC; c++) begin
                if (w_rem[c*DW +: DW] >= w_dvs) begin
                    n_rem[c*DW +: DW] = w_rem[c*DW +: DW] - w_dvs;
                    n_q[c*QB +: QB]   = {w_q[c*QB +: QB-1], 1'b1};
                end else begin
                    n_rem[c*DW +: DW] = w_rem[c*DW +: DW];
                    n_q[c*QB +: QB]   = {w_q[c*QB +: QB-1], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_dv[j+1] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dlen[j+1] <= w_len;
                r_drem[j+1] <= n_rem;
                r_dq[j+1]   <= n_q;
                r_dneg[j+1] <= w_neg;
            end
        end
    end

    // Sign restore; zero length forces zero outputs
    always_comb begin
        n_zl = r_dlen[NS] == '0;
        for (int c = 0; c < NC; c++) begin
            if (n_zl) begin
                n_unit[c*(F+2) +: F+2] = '0;
            end else if (r_dneg[NS][c]) begin
                n_unit[c*(F+2) +: F+2] = -{1'b0, r_dq[NS][c*QB +: QB]};
            end else begin
                n_unit[c*(F+2) +: F+2] = {1'b0, r_dq[NS][c*QB +: QB]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_ov <= r_dv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ux <= n_unit[0*(F+2) +: F+2];
            r_uy <= n_unit[1*(F+2) +: F+2];
            r_uz <= n_unit[2*(F+2) +: F+2];
            r_zl <= n_zl;
        end
    end

endmodule

// ===== design/vector3_normalize_top.sv =====
// Stages: 3 front stages, the queue storage, COMP_WIDTH root stages,
//   FRAC_BITS+1 quotient stages and 1 output stage.
// Throughput: one vector per cycle when i_ready does not stall the output; every stage is a separate register.
// A 4-entry queue sits between the square-sum front and the root/divide back.
// Reset (synchronous, active low) clears valid bits, queue pointers and queue fill count only.
// Depends on vn_pkg, vn_front, vn_queue, vn_back.
module vector3_normalize_top #(
    parameter int FRAC_BITS  = 16,
    parameter int COMP_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [31:0]           i_comp_x,
    input  logic [31:0]           i_comp_y,
    input  logic [31:0]           i_comp_z,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [FRAC_BITS+1:0]  o_unit_x,
    output logic [FRAC_BITS+1:0]  o_unit_y,
    output logic [FRAC_BITS+1:0]  o_unit_z,
    output logic                  o_zero_length
);
    localparam int CW = COMP_WIDTH;
    localparam int NC = vn_pkg::NUM_COMP;
    localparam int QW = NC*CW + NC + 2*CW;

    logic [NC*CW-1:0] w_comp;
    logic             w_fv, w_fr, w_bv, w_br;
    logic [NC*CW-1:0] w_fmag, w_bmag;
    logic [NC-1:0]    w_fneg, w_bneg;
    logic [2*CW-1:0]  w_fsum, w_bsum;

    assign w_comp = {i_comp_z[CW-1:0], i_comp_y[CW-1:0], i_comp_x[CW-1:0]};

    vn_front #(.CW(CW)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_comp  (w_comp),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_mag   (w_fmag),
        .o_neg   (w_fneg),
        .o_sum   (w_fsum)
    );

    vn_queue #(.W(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_data  ({w_fmag, w_fneg, w_fsum}),
        .o_valid (w_bv),
        .i_ready (w_br),
        .o_data  ({w_bmag, w_bneg, w_bsum})
    );

    vn_back #(.CW(CW), .F(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_bv),
        .o_ready       (w_br),
        .i_mag         (w_bmag),
        .i_neg         (w_bneg),
        .i_sum         (w_bsum),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_unit_x      (o_unit_x),
        .o_unit_y      (o_unit_y),
        .o_unit_z      (o_unit_z),
        .o_zero_length (o_zero_length)
    );

    // A zero-length result carries all-zero components
    a_zero_units: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_length |-> o_unit_x == '0 && o_unit_y == '0 && o_unit_z == '0)
        else $error("zero length with nonzero unit");

    // The x component stays within plus or minus one
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $signed(o_unit_x) <= $signed((FRAC_BITS+2)'(1) << FRAC_BITS)
                 && $signed(o_unit_x) >= -$signed((FRAC_BITS+2)'(1) << FRAC_BITS))
        else $error("unit_x out of range");

    // Queue hands items to the back only when the back can take them
    a_queue_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_bv && w_br |=> !$past(o_valid && !i_ready))
        else $error("back advanced while stalled");

endmodule

// ===== tb/vector3_normalize_top_tb.sv =====
// Testbench for vector3_normalize_top: directed table plus random vectors; typed rows
// are checked against their table results, all others against a local fixed-point
// normalization predictor. Depends on vector3_normalize_top (and vn_pkg through it).
`timescale 1ns / 1ps

module vector3_normalize_top_tb;

    localparam int FRAC_BITS  = 16;
    localparam int COMP_WIDTH = 32;
    localparam int OUT_W      = FRAC_BITS + 2;
    localparam int N_RANDOM   = 400;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [OUT_W-1:0] ux;
        logic [OUT_W-1:0] uy;
        logic [OUT_W-1:0] uz;
        logic             zl;
    } unit_vec_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        bit          typed;
        unit_vec_t   res;
    } vec_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [31:0]       i_comp_x;
    logic [31:0]       i_comp_y;
    logic [31:0]       i_comp_z;
    logic              o_valid;
    logic              i_ready;
    logic [OUT_W-1:0]  o_unit_x;
    logic [OUT_W-1:0]  o_unit_y;
    logic [OUT_W-1:0]  o_unit_z;
    logic              o_zero_length;

    unit_vec_t   unit_fifo[$];
    int          err_count;
    int          vec_count;
    int          zero_count;
    int          quiet_cycles;
    int          idle_pct_in;
    int          idle_pct_out;
    bit          stim_done;

    vector3_normalize_top #(
        .FRAC_BITS (FRAC_BITS),
        .COMP_WIDTH(COMP_WIDTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_comp_x     (i_comp_x),
        .i_comp_y     (i_comp_y),
        .i_comp_z     (i_comp_z),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_unit_x     (o_unit_x),
        .o_unit_y     (o_unit_y),
        .o_unit_z     (o_unit_z),
        .o_zero_length(o_zero_length)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Magnitude of a component after sign extension from COMP_WIDTH-1
    function automatic logic [63:0] comp_mag(input logic [31:0] raw, output bit neg);
        logic [63:0] v;
        v = 64'(raw[COMP_WIDTH-1:0]);
        neg = raw[COMP_WIDTH-1];
        if (neg)
            v = 64'(((~raw[COMP_WIDTH-1:0]) + 1'b1) & {COMP_WIDTH{1'b1}});
        if (neg && v == 0)
            v = 64'd1 << (COMP_WIDTH - 1);
        return v;
    endfunction

    // Floor square root, one result bit per iteration
    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if ({64'd0, trial} * {64'd0, trial} <= {64'd0, n})
                root = trial;
        end
        return root;
    endfunction

    function automatic unit_vec_t normalize_vec(input logic [31:0] x, y, z);
        logic [63:0]  mag[3];
        bit           neg[3];
        logic [63:0]  sum;
        logic [63:0]  len;
        logic [127:0] q;
        logic [OUT_W-1:0] u[3];
        unit_vec_t    r;
        mag[0] = comp_mag(x, neg[0]);
        mag[1] = comp_mag(y, neg[1]);
        mag[2] = comp_mag(z, neg[2]);
        sum = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = isqrt64(sum);
        if (len == 0) begin
            r = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
            return r;
        end
        for (int k = 0; k < 3; k++) begin
            q = ({64'd0, mag[k]} << FRAC_BITS) / {64'd0, len};
            if (neg[k])
                q = -q;
            u[k] = q[OUT_W-1:0];
        end
        r = '{ux: u[0], uy: u[1], uz: u[2], zl: 1'b0};
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got, exp_v);
        err_count++;
        $display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, exp_v, vec_count);
    endtask

    // Drive one vector; expectation queued when the transfer happens
    task automatic send_vec(input logic [31:0] x, y, z, input bit typed, input unit_vec_t res);
        while (($urandom_range(99) < idle_pct_in)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_comp_x <= x;
        i_comp_y <= y;
        i_comp_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        unit_fifo.push_back(typed ? res : normalize_vec(x, y, z));
        @(negedge i_clk);
    endtask

    // Receiver: random back-pressure, sampled at rising edge
    always @(negedge i_clk)
        i_ready <= ($urandom_range(99) >= idle_pct_out);

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (unit_fifo.size() == 0) begin
                report_mismatch("unexpected result", 32'(o_unit_x), 32'd0);
            end else begin
                unit_vec_t e;
                e = unit_fifo.pop_front();
                if (o_unit_x !== e.ux) report_mismatch("unit_x", 32'(o_unit_x), 32'(e.ux));
                if (o_unit_y !== e.uy) report_mismatch("unit_y", 32'(o_unit_y), 32'(e.uy));
                if (o_unit_z !== e.uz) report_mismatch("unit_z", 32'(o_unit_z), 32'(e.uz));
                if (o_zero_length !== e.zl)
                    report_mismatch("zero_length", 32'(o_zero_length), 32'(e.zl));
                if (e.zl) zero_count++;
            end
            vec_count++;
        end
    end

    // Watchdog: cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n || stim_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3: return 32'(signed'($urandom_range(131072)) - 65536);
            4: return 32'd0;
            default: return $urandom >> $urandom_range(31);
        endcase
    endfunction

    localparam unit_vec_t ZERO_RES = '{ux: '0, uy: '0, uz: '0, zl: 1'b1};
    localparam unit_vec_t NONE_RES = '{ux: '0, uy: '0, uz: '0, zl: 1'b0};
    localparam logic [OUT_W-1:0] ONE  = OUT_W'(1 << FRAC_BITS);
    localparam logic [OUT_W-1:0] MONE = -OUT_W'(1 << FRAC_BITS);

    vec_row_t dir_rows[$];

    initial begin
        err_count = 0; vec_count = 0; zero_count = 0; quiet_cycles = 0;
        stim_done = 0;
        idle_pct_in = 0; idle_pct_out = 0;
        i_rst_n = 1'b0; i_valid = 1'b0; i_ready = 1'b0;
        i_comp_x = '0; i_comp_y = '0; i_comp_z = '0;

        // Directed table: zero vector, axis extremes, most negative, mixes
        dir_rows = '{
            '{32'h0, 32'h0, 32'h0, 1'b1, ZERO_RES},
            '{32'h0001_0000, 32'h0, 32'h0, 1'b1, '{ONE, '0, '0, 1'b0}},
            '{32'h0, 32'hFFFF_0000, 32'h0, 1'b1, '{'0, MONE, '0, 1'b0}},
            '{32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1, '{'0, '0, ONE, 1'b0}},
            '{32'h8000_0000, 32'h0, 32'h0, 1'b1, '{MONE, '0, '0, 1'b0}},
            '{32'h0, 32'h0, 32'h8000_0000, 1'b1, '{'0, '0, MONE, 1'b0}},
            '{32'h1, 32'h0, 32'h0, 1'b1, '{ONE, '0, '0, 1'b0}},
            '{32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, '{MONE, '0, '0, 1'b0}},
            '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, NONE_RES},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, NONE_RES},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h1, 1'b0, NONE_RES},
            '{32'h0003_0000, 32'h0004_0000, 32'h0, 1'b0, NONE_RES},
            '{32'h1, 32'h1, 32'h1, 1'b0, NONE_RES},
            '{32'hFFFF_FFFF, 32'h1, 32'hFFFF_FFFF, 1'b0, NONE_RES},
            '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F, 1'b0, NONE_RES},
            '{32'hAAAA_AAAA, 32'h5555_5555, 32'hF0F0_F0F0, 1'b0, NONE_RES}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[r])
            send_vec(dir_rows[r].x, dir_rows[r].y, dir_rows[r].z,
                     dir_rows[r].typed, dir_rows[r].res);

        // Random part: first a stretch with no idling, then ~31% idling
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 0) begin
                idle_pct_in = 0; idle_pct_out = 0;
            end else if (n == 80) begin
                idle_pct_in = 31; idle_pct_out = 31;
            end
            send_vec(rand_comp(), rand_comp(), rand_comp(), 1'b0, NONE_RES);
        end
        i_valid <= 1'b0;

        stim_done = 1'b1;
        for (int w = 0; w < 20000 && unit_fifo.size() != 0; w++)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d normalized vectors (%0d zero-length), directed and random,",
                 vec_count, zero_count);
        $display("with random idle and back-pressure on both channels.");
        if (err_count == 0 && unit_fifo.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d errors, %0d results outstanding", err_count, unit_fifo.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
